/* hw/rtl/btpc_pkg.sv */
// Shared types and constants for the barometric compensation pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package btpc_pkg;

  // Field widths
  localparam int CAL_W     = 16;
  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 32;
  localparam int CFG_IDX_W = 3;

  // Internal datapath widths
  localparam int OFF_W  = 36;
  localparam int SENS_W = 35;
  localparam int SQ_W   = 35;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF            = CFG_IDX_W'(5);

  // Temperature thresholds in hundredths of a degree
  localparam logic signed [TEMP_W-1:0] T_REF = TEMP_W'(2000);
  localparam logic signed [TEMP_W-1:0] T_LOW = -TEMP_W'(1500);

  // Calibration words
  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } btpc_cal_t;

  // Beat handed from the temperature stages to the pressure stages
  typedef struct packed {
    logic        [RAW_W-1:0]  d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
    logic        [SQ_W-1:0]   sq_ref;
    logic        [SQ_W-1:0]   sq_low;
    logic                     lt_ref;
    logic                     lt_low;
  } btpc_mid_t;

endpackage

`default_nettype wire

/* hw/rtl/btpc_cfg.sv */
// Calibration register file: six 16-bit words written through a plain port.
// Depends on btpc_pkg for the register indexes and the calibration struct.
`default_nettype none

module btpc_cfg import btpc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_wdata,
  output btpc_cal_t                 cal
);

  btpc_cal_t cal_r;
  btpc_cal_t cal_nxt;

  // Decode the write; drop indexes past the last word
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PRESSURE_SENSITIVITY:  cal_nxt.c1 = cfg_wdata;
        REG_PRESSURE_OFFSET:       cal_nxt.c2 = cfg_wdata;
        REG_SENS_TEMP_COEFF:       cal_nxt.c3 = cfg_wdata;
        REG_OFFSET_TEMP_COEFF:     cal_nxt.c4 = cfg_wdata;
        REG_REFERENCE_TEMPERATURE: cal_nxt.c5 = cfg_wdata;
        REG_TEMP_COEFF:            cal_nxt.c6 = cfg_wdata;
        default:                   cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

`default_nettype wire

/* hw/rtl/btpc_temp.sv */
// Temperature stages: dT, first-order T/OFF/SENS, the squared correction terms
// and the corrected temperature. Four register stages; depends on btpc_pkg.
`default_nettype none

module btpc_temp import btpc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic [RAW_W-1:0] d1,
  input  wire logic [RAW_W-1:0] d2,
  input  wire btpc_cal_t        cal,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output btpc_mid_t             mid
);

  localparam int STAGES = 4;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] rdy;
  logic [STAGES-1:0] ld;

  // Stage control: a stage takes a beat when it is empty or drains this cycle
  always_comb begin
    rdy[STAGES-1] = !valid_r[STAGES-1] || dn_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && up_valid;
    for (int k = 1; k < STAGES; k++) begin
      ld[k] = rdy[k] && valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) valid_r[0] <= up_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // Stage 1: dT = D2 - C5 * 2^8
  logic        [RAW_W-1:0] s1_d1_r;
  logic signed [RAW_W:0]   s1_dt_r;
  logic signed [RAW_W:0]   s1_dt_nxt;

  assign s1_dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, cal.c5, 8'b0});

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_d1_r <= d1;
      s1_dt_r <= s1_dt_nxt;
    end
  end

  // Stage 2: products of dT with the coefficients, and dT squared
  logic        [RAW_W-1:0] s2_d1_r;
  logic signed [41:0]      s2_pt_r;
  logic signed [41:0]      s2_poff_r;
  logic signed [41:0]      s2_psens_r;
  logic        [16:0]      s2_t2_r;
  logic signed [41:0]      s2_pt_nxt;
  logic signed [41:0]      s2_poff_nxt;
  logic signed [41:0]      s2_psens_nxt;
  logic signed [49:0]      dtsq;

  assign s2_pt_nxt    = s1_dt_r * $signed({1'b0, cal.c6});
  assign s2_poff_nxt  = s1_dt_r * $signed({1'b0, cal.c4});
  assign s2_psens_nxt = s1_dt_r * $signed({1'b0, cal.c3});
  assign dtsq         = s1_dt_r * s1_dt_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s2_d1_r    <= s1_d1_r;
      s2_pt_r    <= s2_pt_nxt;
      s2_poff_r  <= s2_poff_nxt;
      s2_psens_r <= s2_psens_nxt;
      // T2 = dT^2 / 2^31, dT^2 never negative
      s2_t2_r    <= dtsq[47:31];
    end
  end

  // Stage 3: first-order T, OFF, SENS; shifts round toward zero
  logic                     pt_corr;
  logic                     poff_corr;
  logic                     psens_corr;
  logic        [RAW_W-1:0]  s3_d1_r;
  logic signed [TEMP_W-1:0] s3_temp_r;
  logic signed [OFF_W-1:0]  s3_off_r;
  logic signed [SENS_W-1:0] s3_sens_r;
  logic        [16:0]       s3_t2_r;
  logic signed [TEMP_W-1:0] s3_temp_nxt;
  logic signed [OFF_W-1:0]  s3_off_nxt;
  logic signed [SENS_W-1:0] s3_sens_nxt;

  assign pt_corr    = s2_pt_r[41] && (|s2_pt_r[22:0]);
  assign poff_corr  = s2_poff_r[41] && (|s2_poff_r[6:0]);
  assign psens_corr = s2_psens_r[41] && (|s2_psens_r[7:0]);

  assign s3_temp_nxt = $signed(s2_pt_r[41:23]) + $signed({1'b0, pt_corr}) + T_REF;
  assign s3_off_nxt  = $signed({4'b0, cal.c2, 16'b0}) + $signed(s2_poff_r[41:7])
                     + $signed({1'b0, poff_corr});
  assign s3_sens_nxt = $signed({4'b0, cal.c1, 15'b0}) + $signed(s2_psens_r[41:8])
                     + $signed({1'b0, psens_corr});

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s3_d1_r   <= s2_d1_r;
      s3_temp_r <= s3_temp_nxt;
      s3_off_r  <= s3_off_nxt;
      s3_sens_r <= s3_sens_nxt;
      s3_t2_r   <= s2_t2_r;
    end
  end

  // Stage 4: threshold tests on first-order T, squares, corrected temperature
  logic signed [TEMP_W-1:0]   a_ref;
  logic signed [TEMP_W-1:0]   b_low;
  logic signed [2*TEMP_W-1:0] sq_a;
  logic signed [2*TEMP_W-1:0] sq_b;
  btpc_mid_t                  mid_r;
  btpc_mid_t                  mid_nxt;

  assign a_ref = s3_temp_r - T_REF;
  assign b_low = s3_temp_r - T_LOW;
  assign sq_a  = a_ref * a_ref;
  assign sq_b  = b_low * b_low;

  always_comb begin
    mid_nxt.d1     = s3_d1_r;
    mid_nxt.off    = s3_off_r;
    mid_nxt.sens   = s3_sens_r;
    mid_nxt.sq_ref = sq_a[SQ_W-1:0];
    mid_nxt.sq_low = sq_b[SQ_W-1:0];
    mid_nxt.lt_ref = s3_temp_r < T_REF;
    mid_nxt.lt_low = s3_temp_r < T_LOW;
    mid_nxt.temp   = s3_temp_r;
    if (s3_temp_r < T_REF) begin
      mid_nxt.temp = s3_temp_r - $signed({2'b0, s3_t2_r});
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      mid_r <= mid_nxt;
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = valid_r[STAGES-1];
  assign mid      = mid_r;

`ifndef ASSERT_OFF
  // A held beat in the last stage is not dropped
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[STAGES-1] && !dn_ready |=> valid_r[STAGES-1])
    else $error("temp stage dropped a stalled beat");

  // The low-temperature correction only applies inside the below-reference band
  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[STAGES-1] && mid_r.lt_low |-> mid_r.lt_ref)
    else $error("low band flagged outside the reference band");
`endif

endmodule

`default_nettype wire

/* hw/rtl/btpc_press.sv */
// Pressure stages: second-order OFF2/SENS2, split D1*SENS product, the two
// truncating shifts and 32-bit sign extension. Six register stages; uses btpc_pkg.
`default_nettype none

module btpc_press import btpc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire btpc_mid_t            mid,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output logic signed [TEMP_W-1:0]  temperature,
  output logic signed [PRES_W-1:0]  pressure
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] rdy;
  logic [STAGES-1:0] ld;

  // Stage control: a stage takes a beat when it is empty or drains this cycle
  always_comb begin
    rdy[STAGES-1] = !valid_r[STAGES-1] || dn_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && up_valid;
    for (int k = 1; k < STAGES; k++) begin
      ld[k] = rdy[k] && valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) valid_r[0] <= up_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // Stage 5: OFF2 and SENS2 from the squared terms
  logic [37:0] sq_a5;
  logic [37:0] sq_b7;
  logic [38:0] sq_b11;
  logic [39:0] off2_nxt;
  logic [39:0] sens2_nxt;

  assign sq_a5  = 38'({mid.sq_ref, 2'b0}) + 38'(mid.sq_ref);
  assign sq_b7  = 38'({mid.sq_low, 3'b0}) - 38'(mid.sq_low);
  assign sq_b11 = 39'({mid.sq_low, 3'b0}) + 39'({mid.sq_low, 1'b0}) + 39'(mid.sq_low);

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (mid.lt_ref) begin
      off2_nxt  = 40'(sq_a5[37:1]);
      sens2_nxt = 40'(sq_a5[37:2]);
    end
    if (mid.lt_low) begin
      off2_nxt  = off2_nxt + 40'(sq_b7);
      sens2_nxt = sens2_nxt + 40'(sq_b11[38:1]);
    end
  end

  logic        [RAW_W-1:0]  s5_d1_r;
  logic signed [TEMP_W-1:0] s5_temp_r;
  logic signed [OFF_W-1:0]  s5_off_r;
  logic signed [SENS_W-1:0] s5_sens_r;
  logic        [39:0]       s5_off2_r;
  logic        [39:0]       s5_sens2_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s5_d1_r    <= mid.d1;
      s5_temp_r  <= mid.temp;
      s5_off_r   <= mid.off;
      s5_sens_r  <= mid.sens;
      s5_off2_r  <= off2_nxt;
      s5_sens2_r <= sens2_nxt;
    end
  end

  // Stage 6: corrected OFF and SENS
  logic        [RAW_W-1:0]  s6_d1_r;
  logic signed [TEMP_W-1:0] s6_temp_r;
  logic signed [40:0]       s6_off_r;
  logic signed [40:0]       s6_sens_r;
  logic signed [40:0]       s6_off_nxt;
  logic signed [40:0]       s6_sens_nxt;

  assign s6_off_nxt  = s5_off_r - $signed({1'b0, s5_off2_r});
  assign s6_sens_nxt = s5_sens_r - $signed({1'b0, s5_sens2_r});

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s6_d1_r   <= s5_d1_r;
      s6_temp_r <= s5_temp_r;
      s6_off_r  <= s6_off_nxt;
      s6_sens_r <= s6_sens_nxt;
    end
  end

  // Stage 7: D1 * SENS as two partial products on the low and high halves
  logic        [TEMP_W-1:0] unused_guard;
  logic        [44:0]       s7_pp_lo_r;
  logic signed [44:0]       s7_pp_hi_r;
  logic        [44:0]       s7_pp_lo_nxt;
  logic signed [44:0]       s7_pp_hi_nxt;
  logic signed [40:0]       s7_off_r;
  logic signed [TEMP_W-1:0] s7_temp_r;

  assign unused_guard = '0;
  assign s7_pp_lo_nxt = 45'(s6_d1_r) * 45'(s6_sens_r[20:0]);
  assign s7_pp_hi_nxt = $signed({1'b0, s6_d1_r}) * $signed(s6_sens_r[40:21]);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s7_pp_lo_r <= s7_pp_lo_nxt;
      s7_pp_hi_r <= s7_pp_hi_nxt;
      s7_off_r   <= s6_off_r;
      s7_temp_r  <= s6_temp_r ^ unused_guard;
    end
  end

  // Stage 8: merge the partial products
  logic signed [65:0]       prod_full;
  logic signed [63:0]       s8_prod_r;
  logic signed [40:0]       s8_off_r;
  logic signed [TEMP_W-1:0] s8_temp_r;

  assign prod_full = $signed({s7_pp_hi_r, 21'b0}) + $signed({1'b0, s7_pp_lo_r});

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s8_prod_r <= prod_full[63:0];
      s8_off_r  <= s7_off_r;
      s8_temp_r <= s7_temp_r;
    end
  end

  // Stage 9: product / 2^21 toward zero, minus OFF
  logic                     prod_corr;
  logic signed [43:0]       s9_diff_r;
  logic signed [43:0]       s9_diff_nxt;
  logic signed [TEMP_W-1:0] s9_temp_r;

  assign prod_corr   = s8_prod_r[63] && (|s8_prod_r[20:0]);
  assign s9_diff_nxt = $signed(s8_prod_r[63:21]) + $signed({1'b0, prod_corr}) - s8_off_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s9_diff_r <= s9_diff_nxt;
      s9_temp_r <= s8_temp_r;
    end
  end

  // Stage 10: / 2^15 toward zero, sign-extend to 32 bits
  logic                     diff_corr;
  logic signed [PRES_W-1:0] s10_pres_r;
  logic signed [PRES_W-1:0] s10_pres_nxt;
  logic signed [TEMP_W-1:0] s10_temp_r;

  assign diff_corr    = s9_diff_r[43] && (|s9_diff_r[14:0]);
  assign s10_pres_nxt = $signed(s9_diff_r[43:15]) + $signed({1'b0, diff_corr});

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s10_pres_r <= s10_pres_nxt;
      s10_temp_r <= s9_temp_r;
    end
  end

  assign up_ready    = rdy[0];
  assign dn_valid    = valid_r[STAGES-1];
  assign temperature = s10_temp_r;
  assign pressure    = s10_pres_r;

`ifndef ASSERT_OFF
  // OFF2 is never smaller than SENS2 in either temperature band
  a_corr_order: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] |-> s5_off2_r >= s5_sens2_r)
    else $error("OFF2 below SENS2");

  // A beat held in the shift stage keeps its value
  a_shift_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[4] && !rdy[4] |=> $stable(s9_diff_r) && valid_r[4])
    else $error("held beat in shift stage changed");
`endif

endmodule

`default_nettype wire

/* hw/rtl/baro_temp_pressure_compensation.sv */
// Top level of the barometric compensation block: calibration registers,
// temperature stages and pressure stages. Depends on btpc_pkg and all btpc_* modules.
`default_nettype none

// Compensates one raw pressure/temperature pair per beat with the first-order
// formulas and the second-order corrections below 20.00 and -15.00 degrees.
// The datapath is a ten-stage pipeline (four temperature stages, six pressure
// stages) that accepts one beat per clock while in_stall is low; out_valid rises
// once the beat reaches the last pressure stage, and the result is held there
// while out_stall is high. The depth is set by the multiplier chain: dT
// products, then the squared terms, then D1*SENS split into two partial
// products and merged a stage later. out_stall reaches in_stall through a
// combinational ready chain; empty slots keep filling while the output is
// stalled, so in_stall rises only once all ten stages hold a beat.
// Calibration words must be written only while no beat is in flight.
module baro_temp_pressure_compensation import btpc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [RAW_W-1:0]     in_pressure_raw,
  input  wire logic [RAW_W-1:0]     in_temperature_raw,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [TEMP_W-1:0]  out_temperature,
  output logic signed [PRES_W-1:0]  out_pressure,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]     cfg_wdata
);

  btpc_cal_t cal;
  btpc_mid_t mid;
  logic      in_ready;
  logic      mid_valid;
  logic      mid_ready;

  btpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cal       (cal)
  );

  btpc_temp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .d1       (in_pressure_raw),
    .d2       (in_temperature_raw),
    .cal      (cal),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .mid      (mid)
  );

  btpc_press u_press (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (mid_valid),
    .up_ready    (mid_ready),
    .mid         (mid),
    .dn_valid    (out_valid),
    .dn_ready    (!out_stall),
    .temperature (out_temperature),
    .pressure    (out_pressure)
  );

  assign in_stall = !in_ready;

endmodule

`default_nettype wire
